// ----- design/ffsa_pkg.sv -----
// ============================================================================
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ============================================================================
package ffsa_pkg;

    localparam int MaxSegments = 64;
    localparam int IdxW        = $clog2(MaxSegments);
    localparam int CntW        = $clog2(MaxSegments + 1);
    localparam int SizeW       = 24;
    localparam int OwnerW      = 16;
    localparam int StatusW     = 3;
    localparam int UsedW       = 7;

    localparam logic [SizeW-1:0] TotalSizeReset = 24'd1024;

    typedef enum logic [StatusW-1:0] {
        ST_ALLOCATED  = 3'd0,
        ST_NO_FIT     = 3'd1,
        ST_FREED      = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    // One segment table entry
    typedef struct packed {
        logic              free;
        logic [OwnerW-1:0] owner;
        logic [SizeW-1:0]  size;
    } seg_t;

    // Datapath operations driven by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_RESET,     // table becomes one free segment of the reset size
        OP_INIT,      // table becomes one free segment of total_size
        OP_LOAD,      // latch the request
        OP_TAKE,      // entry wr_idx becomes the request, keep the remainder
        OP_MOVE,      // write the read entry to wr_idx (insert gap)
        OP_INSERT,    // free remainder goes to wr_idx
        OP_FREE,      // free the read entry at wr_idx when it belongs to owner
        OP_ACC_FIRST, // start the merge accumulator with the read entry
        OP_ACC,       // merge the read entry into the accumulator or emit it
        OP_FLUSH      // emit the accumulator, set the new count
    } dp_op_t;

    typedef struct packed {
        dp_op_t          op;
        logic [IdxW-1:0] rd_idx;
        logic [IdxW-1:0] wr_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic            req_zero;   // request size is zero
        logic            kind_dealloc;
        logic            fit;        // read entry free and large enough
        logic            exact;      // read entry size equals request
        logic            hit;        // deallocate found its owner
        logic [CntW-1:0] count;
    } dp_stat_t;

endpackage

// ----- design/ffsa_datapath.sv -----
// ============================================================================
// ffsa_datapath
// Segment table memory, request latch, merge accumulator and compare logic.
// ============================================================================
module ffsa_datapath
    import ffsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SizeW-1:0]  total_size,
    input  logic              in_kind,
    input  logic [OwnerW-1:0] in_owner,
    input  logic [SizeW-1:0]  in_size,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat
);

    seg_t              mem [MaxSegments];
    seg_t              rd_reg;
    seg_t              acc_reg, acc_next;
    logic [IdxW-1:0]   wp_reg, wp_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              kind_reg;
    logic [OwnerW-1:0] req_owner_reg;
    logic [SizeW-1:0]  req_size_reg;
    logic [SizeW-1:0]  rem_reg, rem_next;
    logic              hit_reg, hit_next;
    logic              we;
    logic [IdxW-1:0]   waddr;
    seg_t              wdata;
    logic              owned;
    logic              both_free;

    assign owned     = !rd_reg.free && (rd_reg.owner == req_owner_reg);
    assign both_free = acc_reg.free && rd_reg.free;

    // Status toward the controller; fit and exact come from the registered read entry
    assign stat.req_zero     = (req_size_reg == '0);
    assign stat.kind_dealloc = kind_reg;
    assign stat.fit          = rd_reg.free && (rd_reg.size >= req_size_reg);
    assign stat.exact        = (rd_reg.size == req_size_reg);
    assign stat.hit          = hit_reg;
    assign stat.count        = count_reg;

    // Operation decode: one table write per cycle at most
    always_comb begin
        count_next = count_reg;
        hit_next   = hit_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        wp_next    = wp_reg;
        we         = 1'b0;
        waddr      = cmd.wr_idx;
        wdata      = rd_reg;
        unique case (cmd.op)
            OP_RESET: begin
                count_next  = CntW'(1);
                we          = 1'b1;
                waddr       = '0;
                wdata.free  = 1'b1;
                wdata.owner = '0;
                wdata.size  = TotalSizeReset;
            end
            OP_INIT: begin
                count_next  = CntW'(1);
                we          = 1'b1;
                waddr       = '0;
                wdata.free  = 1'b1;
                wdata.owner = '0;
                wdata.size  = total_size;
            end
            OP_LOAD: hit_next = 1'b0;
            OP_TAKE: begin
                we          = 1'b1;
                wdata.free  = 1'b0;
                wdata.owner = req_owner_reg;
                wdata.size  = req_size_reg;
                rem_next    = rd_reg.size - req_size_reg;
            end
            OP_MOVE: we = 1'b1;
            OP_INSERT: begin
                we          = 1'b1;
                wdata.free  = 1'b1;
                wdata.owner = '0;
                wdata.size  = rem_reg;
                count_next  = count_reg + CntW'(1);
            end
            OP_FREE: begin
                if (owned) begin
                    we          = 1'b1;
                    wdata.free  = 1'b1;
                    wdata.owner = '0;
                    hit_next    = 1'b1;
                end
            end
            OP_ACC_FIRST: begin
                acc_next = rd_reg;
                wp_next  = '0;
            end
            OP_ACC: begin
                if (both_free) begin
                    acc_next.size = acc_reg.size + rd_reg.size;
                end else begin
                    we       = 1'b1;
                    waddr    = wp_reg;
                    wdata    = acc_reg;
                    wp_next  = wp_reg + IdxW'(1);
                    acc_next = rd_reg;
                end
            end
            OP_FLUSH: begin
                we         = 1'b1;
                waddr      = wp_reg;
                wdata      = acc_reg;
                count_next = CntW'(wp_reg) + CntW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CntW'(1);
            hit_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            hit_reg   <= hit_next;
        end
    end

    // Request latch and working registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        wp_reg  <= wp_next;
        if (cmd.op == OP_LOAD) begin
            kind_reg      <= in_kind;
            req_owner_reg <= in_owner;
            req_size_reg  <= in_size;
        end
    end

    // Segment table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[cmd.rd_idx];
    end

endmodule

// ----- design/ffsa_ctrl.sv -----
// ============================================================================
// ffsa_ctrl
// Sequencer: first-fit scan, insert shift, owner free and merge passes.
// ============================================================================
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [StatusW-1:0]  m_status,
    output logic [UsedW-1:0]    m_segments_used,
    output dp_cmd_t             cmd,
    input  dp_stat_t            stat
);

    typedef enum logic [10:0] {
        S_INIT  = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_DISP  = 11'b000_0000_0100,
        S_SCAN  = 11'b000_0000_1000,
        S_SHIFT = 11'b000_0001_0000,
        S_INS   = 11'b000_0010_0000,
        S_FREE  = 11'b000_0100_0000,
        S_PRIME = 11'b000_1000_0000,
        S_MERGE = 11'b001_0000_0000,
        S_FLUSH = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [IdxW-1:0] idx_reg, idx_next;   // entry held in the read register
    logic [IdxW-1:0] pos_reg, pos_next;   // split position
    status_t         st_reg, st_next;
    logic            mv_reg, mv_next;
    logic [StatusW-1:0] ms_reg, ms_next;
    logic [UsedW-1:0]   mu_reg, mu_next;
    logic [CntW-1:0]    last;
    logic               out_free;

    assign out_free  = !mv_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_valid   = mv_reg;
    assign m_status  = ms_reg;
    assign m_segments_used = mu_reg;
    assign last = stat.count - CntW'(1);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        st_next    = st_reg;
        mv_next    = mv_reg && !m_ready;
        ms_next    = ms_reg;
        mu_next    = mu_reg;
        cmd.op     = OP_NONE;
        cmd.rd_idx = idx_reg + IdxW'(1);   // prefetch the next entry
        cmd.wr_idx = idx_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.op     = OP_RESET;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (cfg_valid) begin
                    cmd.op = OP_INIT;
                end else if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    idx_next   = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cmd.rd_idx = '0;
                if (stat.kind_dealloc) state_next = S_FREE;
                else if (stat.req_zero) begin
                    st_next    = ST_NO_FIT;
                    state_next = S_DONE;
                end else state_next = S_SCAN;
            end
            S_SCAN: begin
                if (stat.fit) begin
                    if (!stat.exact && stat.count == CntW'(MaxSegments)) begin
                        st_next    = ST_TABLE_FULL;
                        state_next = S_DONE;
                    end else begin
                        cmd.op = OP_TAKE;
                        if (stat.exact) begin
                            st_next    = ST_ALLOCATED;
                            state_next = S_DONE;
                        end else begin
                            pos_next = idx_reg;
                            if ({1'b0, idx_reg} == last) begin
                                state_next = S_INS;
                            end else begin
                                // start moving entries up from the top
                                cmd.rd_idx = last[IdxW-1:0];
                                idx_next   = last[IdxW-1:0];
                                state_next = S_SHIFT;
                            end
                        end
                    end
                end else if ({1'b0, idx_reg} == last) begin
                    st_next    = ST_NO_FIT;
                    state_next = S_DONE;
                end else idx_next = idx_reg + IdxW'(1);
            end
            S_SHIFT: begin
                // entry idx moves to idx+1 while idx-1 is read
                cmd.op     = OP_MOVE;
                cmd.wr_idx = idx_reg + IdxW'(1);
                cmd.rd_idx = idx_reg - IdxW'(1);
                if (idx_reg == pos_reg + IdxW'(1)) state_next = S_INS;
                else idx_next = idx_reg - IdxW'(1);
            end
            S_INS: begin
                cmd.op     = OP_INSERT;
                cmd.wr_idx = pos_reg + IdxW'(1);
                st_next    = ST_ALLOCATED;
                state_next = S_DONE;
            end
            S_FREE: begin
                cmd.op = OP_FREE;
                if ({1'b0, idx_reg} == last) state_next = S_PRIME;
                else idx_next = idx_reg + IdxW'(1);
            end
            S_PRIME: begin
                // reread entry 0 once every free has landed
                cmd.rd_idx = '0;
                idx_next   = '0;
                if (!stat.hit) begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_DONE;
                end else state_next = S_MERGE;
            end
            S_MERGE: begin
                if (idx_reg == '0) cmd.op = OP_ACC_FIRST;
                else cmd.op = OP_ACC;
                if ({1'b0, idx_reg} == last) state_next = S_FLUSH;
                else idx_next = idx_reg + IdxW'(1);
            end
            S_FLUSH: begin
                cmd.op     = OP_FLUSH;
                st_next    = ST_FREED;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    ms_next    = st_reg;
                    mu_next    = UsedW'(stat.count);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        st_reg  <= st_next;
        ms_reg  <= ms_next;
        mu_reg  <= mu_next;
    end

endmodule

// ----- design/first_fit_segment_allocator.sv -----
// ============================================================================
// first_fit_segment_allocator
// First-fit allocator over an ordered segment table with free-run merging.
// ============================================================================
// Usage:
//   s_ channel beats carry one request: kind (0 allocate, 1 deallocate),
//   owner_id and request_size. Each beat yields exactly one m_ beat with
//   status and the segment count after the operation.
//   cfg_ beats write total_size and reset the table to one free segment;
//   write only while no request is in flight.
//   A zero-size allocate returns no fit without a scan. An allocate scans the
//   table entry by entry; on a split it moves any entries above the split up
//   and writes the free remainder. A deallocate makes a free pass over the
//   table and, when the owner is found, a merge pass. The table memory, with
//   one entry read per cycle, sets the pace. One request is in work at a
//   time; the next is accepted once the controller is back in idle after the
//   result is registered.
//   Reset: the cycle after reset the table is written to one free segment of
//   1024 units, then s_ready rises. No result pending.
//   A stalled m_ channel holds its beat; the block finishes the next request
//   and waits in its final state until the output register frees.
// ============================================================================
module first_fit_segment_allocator
    import ffsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SizeW-1:0]    cfg_total_size,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [OwnerW-1:0]   s_owner_id,
    input  logic [SizeW-1:0]    s_request_size,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [StatusW-1:0]  m_status,
    output logic [UsedW-1:0]    m_segments_used
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffsa_ctrl u_ctrl (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .s_valid, .s_ready,
        .m_valid, .m_ready, .m_status, .m_segments_used, .cmd, .stat
    );

    ffsa_datapath u_dp (
        .aclk, .aresetn,
        .total_size (cfg_total_size),
        .in_kind    (s_kind),
        .in_owner   (s_owner_id),
        .in_size    (s_request_size),
        .cmd, .stat
    );

    // count stays in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count >= CntW'(1) && stat.count <= CntW'(MaxSegments))
        else $error("segment count out of range");

    // no new request while a result is being produced
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // reported count is valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_segments_used != '0)
        else $error("zero segments reported");

endmodule
